[hw/rtl/mexp_pkg.sv]
// shared types and constants for the modular exponentiation block
package mexp_pkg;

  localparam int DataW     = 64;
  localparam int ModW      = 63;
  localparam int ExpW      = 63;
  localparam int InTdataW  = 192;
  localparam int OutTdataW = 64;
  localparam int BaseLsb   = 0;
  localparam int ExpLsb    = 64;
  localparam int ModLsb    = 128;
  localparam int HalfW     = 32;
  localparam int ProdW     = 128;
  localparam int MulParts  = 4;
  localparam int RedCntW   = 7;
  localparam int QueueDepth = 2;
  localparam int QPtrW     = 1;
  localparam int QCntW     = 2;

  localparam logic [ModW-1:0] ResetModulus = {ModW{1'b1}};

  typedef enum logic [1:0] {
    KIND_RUN,
    KIND_ONE,
    KIND_ERR
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [DataW-1:0]  base;
    logic [ExpW-1:0]   exp;
    logic [ModW-1:0]   modulus;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DataW-1:0]  a;
    logic [DataW-1:0]  b;
    logic [ModW-1:0]   m;
  } mm_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DataW-1:0]  res;
  } mm_rsp_t;

endpackage

[hw/rtl/mexp_front.sv]
// input side: default modulus register, item classification and queue push
module mexp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mexp_pkg::InTdataW-1:0] s_tdata,
  input  logic [0:0]                    s_tuser,
  input  logic                          cfg_wen,
  input  logic [mexp_pkg::ModW-1:0]     cfg_wdata,
  input  logic                          q_full,
  output logic                          q_push,
  output mexp_pkg::job_t                q_job
);
  import mexp_pkg::*;

  logic [ModW-1:0] default_modulus;
  logic [ModW-1:0] m_eff;
  logic [DataW-1:0] exp_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_modulus <= ResetModulus;
    end else if (cfg_wen) begin
      default_modulus <= cfg_wdata;
    end
  end

  always_comb begin
    exp_in        = s_tdata[ExpLsb +: DataW];
    m_eff         = s_tuser[0] ? s_tdata[ModLsb +: ModW] : default_modulus;
    q_job.base    = s_tdata[BaseLsb +: DataW];
    q_job.exp     = exp_in[ExpW-1:0];
    q_job.modulus = m_eff;
    if (m_eff == '0) begin
      q_job.kind = KIND_ERR;
    end else if (exp_in[DataW-1] || exp_in == '0) begin
      q_job.kind = KIND_ONE;
    end else begin
      q_job.kind = KIND_RUN;
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

endmodule

[hw/rtl/mexp_queue.sv]
// short job queue between the front and the back
module mexp_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  mexp_pkg::job_t              push_job,
  input  logic                        pop,
  output mexp_pkg::job_t              head,
  output logic                        full,
  output logic                        empty,
  output logic [mexp_pkg::QCntW-1:0]  count
);
  import mexp_pkg::*;

  job_t             entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;

  assign full  = count == QCntW'(QueueDepth);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/mexp_mulmod.sv]
// multi-cycle signed modular multiplier: four 32x32 partial products, then bit-serial reduction
module mexp_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  mexp_pkg::mm_req_t req,
  output mexp_pkg::mm_rsp_t rsp
);
  import mexp_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE,
    M_MUL,
    M_RED
  } mstate_t;

  mstate_t             state;
  logic [DataW-1:0]    x;
  logic [DataW-1:0]    y;
  logic                neg;
  logic [ModW-1:0]     m;
  logic [2:0]          mul_cnt;
  logic [RedCntW-1:0]  red_cnt;
  logic [DataW-1:0]    pp;
  logic [1:0]          pp_sel;
  logic [ProdW-1:0]    prod;
  logic [ModW-1:0]     r;
  logic                done;
  logic [DataW-1:0]    res;

  logic [HalfW-1:0]    xs;
  logic [HalfW-1:0]    ys;
  logic [DataW-1:0]    pp_next;
  logic [ProdW-1:0]    pp_shifted;
  logic [DataW-1:0]    t;
  logic [ModW-1:0]     r_next;

  always_comb begin
    xs      = mul_cnt[1] ? x[DataW-1:HalfW] : x[HalfW-1:0];
    ys      = mul_cnt[0] ? y[DataW-1:HalfW] : y[HalfW-1:0];
    pp_next = DataW'(xs) * DataW'(ys);
    case (pp_sel)
      2'd0:    pp_shifted = {{DataW{1'b0}}, pp};
      2'd3:    pp_shifted = {pp, {DataW{1'b0}}};
      default: pp_shifted = {{HalfW{1'b0}}, pp, {HalfW{1'b0}}};
    endcase
    t = {r, prod[ProdW-1]};
    if (t >= {1'b0, m}) begin
      r_next = ModW'(t - {1'b0, m});
    end else begin
      r_next = t[ModW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            x       <= req.a[DataW-1] ? -req.a : req.a;
            y       <= req.b[DataW-1] ? -req.b : req.b;
            neg     <= req.a[DataW-1] ^ req.b[DataW-1];
            m       <= req.m;
            prod    <= '0;
            r       <= '0;
            mul_cnt <= '0;
            state   <= M_MUL;
          end
        end
        M_MUL: begin
          if (mul_cnt != 3'(MulParts)) begin
            pp     <= pp_next;
            pp_sel <= mul_cnt[1:0];
          end
          if (mul_cnt != '0) begin
            prod <= prod + pp_shifted;
          end
          mul_cnt <= mul_cnt + 1'b1;
          if (mul_cnt == 3'(MulParts)) begin
            red_cnt <= '1;
            state   <= M_RED;
          end
        end
        M_RED: begin
          r       <= r_next;
          prod    <= {prod[ProdW-2:0], 1'b0};
          red_cnt <= red_cnt - 1'b1;
          if (red_cnt == '0) begin
            res   <= neg ? -{1'b0, r_next} : {1'b0, r_next};
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign rsp.busy = state != M_IDLE;
  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

[hw/rtl/mexp_back.sv]
// execution side: square-and-multiply sequencer and output register
module mexp_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  mexp_pkg::job_t                 q_head,
  output logic                           q_pop,
  output mexp_pkg::mm_req_t              mm_req,
  input  mexp_pkg::mm_rsp_t              mm_rsp,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mexp_pkg::OutTdataW-1:0] m_tdata,
  output logic [0:0]                     m_tuser
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_WAIT_MUL,
    S_WAIT_SQR,
    S_OUT
  } bstate_t;

  bstate_t           state;
  logic [DataW-1:0]  acc;
  logic [DataW-1:0]  b;
  logic [ExpW-1:0]   e;
  logic [ModW-1:0]   m;
  logic              err;
  logic              mul_done;
  logic              out_valid;
  logic [DataW-1:0]  out_value;
  logic              out_err;
  logic              slot_free;
  logic              do_mul;
  logic              do_sqr;

  assign slot_free = !out_valid || m_tready;
  assign q_pop     = state == S_IDLE && !q_empty;

  always_comb begin
    do_mul = state == S_STEP && e != '0 && e[0] && !mul_done;
    do_sqr = state == S_STEP && e != '0 && !(e[0] && !mul_done) && e != ExpW'(1);
    mm_req.start = do_mul || do_sqr;
    mm_req.a     = do_mul ? acc : b;
    mm_req.b     = b;
    mm_req.m     = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_done  <= 1'b0;
    end else begin
      if (state == S_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            b        <= q_head.base;
            e        <= q_head.exp;
            m        <= q_head.modulus;
            mul_done <= 1'b0;
            case (q_head.kind)
              KIND_ERR: begin
                acc   <= '0;
                err   <= 1'b1;
                state <= S_OUT;
              end
              KIND_ONE: begin
                acc   <= DataW'(1);
                err   <= 1'b0;
                state <= S_OUT;
              end
              default: begin
                acc   <= DataW'(1);
                err   <= 1'b0;
                state <= S_STEP;
              end
            endcase
          end
        end
        S_STEP: begin
          if (do_mul) begin
            state <= S_WAIT_MUL;
          end else if (do_sqr) begin
            state <= S_WAIT_SQR;
          end else begin
            state <= S_OUT;
          end
        end
        S_WAIT_MUL: begin
          if (mm_rsp.done) begin
            acc      <= mm_rsp.res;
            mul_done <= 1'b1;
            state    <= S_STEP;
          end
        end
        S_WAIT_SQR: begin
          if (mm_rsp.done) begin
            b        <= mm_rsp.res;
            e        <= e >> 1;
            mul_done <= 1'b0;
            state    <= S_STEP;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            out_value <= acc;
            out_err   <= err;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_value;
  assign m_tuser[0] = out_err;

endmodule

[hw/rtl/modular_exponentiation.sv]
// top level of the modular exponentiation block
// Computes base^exponent mod modulus by right-to-left square and multiply with
// exact 128-bit products and a truncated remainder whose sign follows the
// dividend. Items are taken into a two-entry queue and worked one at a time;
// every modular product runs on a single shared unit that forms the product
// from four 32x32 partial products and then reduces it one bit per cycle. An
// item with an exponent of bit length L and P set bits needs L - 1 + P modular
// products; an item with a zero modulus or an exponent of zero or less needs
// none and goes straight to the output register.
// A finished result waits in the output register while the next item runs.
module modular_exponentiation (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // base [63:0], exponent [127:64], modulus [190:128], zero [191]
  input  logic [mexp_pkg::InTdataW-1:0]  s_tdata,
  // modulus_present [0]
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // value [63:0]
  output logic [mexp_pkg::OutTdataW-1:0] m_tdata,
  // error [0]
  output logic [0:0]                     m_tuser,
  input  logic                           cfg_wen,
  input  logic [mexp_pkg::ModW-1:0]      cfg_wdata
);
  import mexp_pkg::*;

  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic [QCntW-1:0] q_count;
  job_t             push_job;
  job_t             q_head;
  mm_req_t          mm_req;
  mm_rsp_t          mm_rsp;

  mexp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  mexp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  mexp_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  mexp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .mm_req   (mm_req),
    .mm_rsp   (mm_rsp),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("error item with nonzero value");

  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> q_count != '0)
    else $error("accepted item missing from queue");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
